// ===== src/stpq_pkg.sv =====
// stpq_pkg: shared types and constants of the stable time priority queue
// no dependencies; imported by the interfaces, the queue cell, the top level, the checker and the testbench
`default_nettype none

package stpq_pkg;

  // number of queue cells
  localparam int QUEUE_DEPTH = 16;
  // width of the entry count, able to hold QUEUE_DEPTH itself
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  // width of the reported occupancy field
  localparam int OCC_W = 5;

  // operation codes of a request
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  // one queued event
  typedef struct packed {
    logic signed [31:0] evt_time;
    logic        [15:0] kind;
    logic signed [31:0] data_a;
    logic signed [31:0] data_b;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/stpq_if.sv =====
// stpq_req_if, stpq_rsp_if: valid/ready channels of the queue
// depends on stpq_pkg for the operation code type and the occupancy width OCC_W
`default_nettype none

interface stpq_req_if
  import stpq_pkg::*;
  ();
  logic               valid;
  logic               ready;
  op_t                op;
  logic signed [31:0] event_time;
  logic        [15:0] event_kind;
  logic signed [31:0] data_a;
  logic signed [31:0] data_b;

  modport source (output valid, op, event_time, event_kind, data_a, data_b, input ready);
  modport sink   (input valid, op, event_time, event_kind, data_a, data_b, output ready);
endinterface

interface stpq_rsp_if
  import stpq_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               done_res;
  logic signed [31:0] out_time;
  logic        [15:0] out_kind;
  logic signed [31:0] out_data_a;
  logic signed [31:0] out_data_b;
  logic        [OCC_W-1:0] occupancy;
  logic               is_empty;

  modport source (output valid, done_res, out_time, out_kind, out_data_a, out_data_b,
                  occupancy, is_empty, input ready);
  modport sink   (input valid, done_res, out_time, out_kind, out_data_a, out_data_b,
                  occupancy, is_empty, output ready);
endinterface

`default_nettype wire

// ===== src/stpq_cell.sv =====
// stpq_cell: one slot of the sorted shift-register queue
// depends on stpq_pkg; instantiated in a row by stable_time_priority_queue
`default_nettype none

module stpq_cell
  import stpq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       occupied,
  input  wire logic       left_le,
  input  wire entry_t     left_entry,
  input  wire entry_t     right_entry,
  output logic            le,
  output entry_t          slot
);

  entry_t slot_next;

  // slot holds an event that stays ahead of the new one (ties stay ahead)
  assign le = occupied && (slot.evt_time <= ctrl.new_entry.evt_time);

  // keep, take the new event, shift right on insert; shift left on remove
  always_comb begin
    slot_next = slot;
    if (ctrl.ins) begin
      if (le) begin
        slot_next = slot;
      end else if (left_le) begin
        slot_next = ctrl.new_entry;
      end else begin
        slot_next = left_entry;
      end
    end else if (ctrl.rem) begin
      slot_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    slot <= slot_next;
  end

endmodule

`default_nettype wire

// ===== src/stable_time_priority_queue.sv =====
// Stable time priority queue: a row of QUEUE_DEPTH cells kept in time order.
// Result: registered, and valid in the cycle after its request transaction.
// Throughput: one request per cycle while results are taken; all cells compare
// against the new time in parallel and shift by one place in the same cycle.
// Reset: synchronous; clears the entry count and the result valid, slot contents
// are not reset and are read only below the count.
`default_nettype none

module stable_time_priority_queue
  import stpq_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  stpq_req_if.sink    req,
  stpq_rsp_if.source  rsp
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             fire;
  logic             full;
  cell_ctrl_t       ctrl;
  entry_t           slots [QUEUE_DEPTH];
  logic             les   [QUEUE_DEPTH];

  // accept while the result register is free or being drained
  assign req.ready = !rsp.valid || rsp.ready;
  assign fire      = req.valid && req.ready;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));

  // broadcast to the cells
  assign ctrl.ins = fire && (req.op == OP_INSERT) && !full;
  assign ctrl.rem = fire && (req.op == OP_REMOVE) && (count != '0);
  assign ctrl.new_entry.evt_time = req.event_time;
  assign ctrl.new_entry.kind     = req.event_kind;
  assign ctrl.new_entry.data_a   = req.data_a;
  assign ctrl.new_entry.data_b   = req.data_b;

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   left_le;
    entry_t left_entry;
    entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = ctrl.new_entry;
    end else begin : g_mid
      assign left_le    = les[i-1];
      assign left_entry = slots[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = slots[i];
    end else begin : g_inner
      assign right_entry = slots[i+1];
    end

    stpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (CNT_W'(i) < count),
      .left_le     (left_le),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .le          (les[i]),
      .slot        (slots[i])
    );
  end

  // entry count
  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.rem) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (fire) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // result payload, head entry on a remove
  always_ff @(posedge clk) begin
    if (fire) begin
      rsp.done_res   <= ctrl.ins || ctrl.rem;
      rsp.out_time   <= ctrl.rem ? slots[0].evt_time : '0;
      rsp.out_kind   <= ctrl.rem ? slots[0].kind     : '0;
      rsp.out_data_a <= ctrl.rem ? slots[0].data_a   : '0;
      rsp.out_data_b <= ctrl.rem ? slots[0].data_b   : '0;
      rsp.occupancy  <= OCC_W'(count_next);
      rsp.is_empty   <= (count_next == '0);
    end
  end

endmodule

`default_nettype wire

// ===== src/stpq_checker.sv =====
// stpq_checker: port-level assertions for stable_time_priority_queue
// depends on stpq_pkg; attached to the top level by the bind below
`default_nettype none

module stpq_checker
  import stpq_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic               done_res,
  input wire logic signed [31:0] out_time,
  input wire logic        [15:0] out_kind,
  input wire logic signed [31:0] out_data_a,
  input wire logic signed [31:0] out_data_b,
  input wire logic   [OCC_W-1:0] occupancy,
  input wire logic               is_empty
);

  // a stalled result transaction holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(occupancy) && $stable(out_time))
    else $error("stalled result changed");

  // emptiness matches the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (occupancy == '0)))
    else $error("is_empty disagrees with occupancy");

  // a refused request reports no event
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !done_res |-> out_time == '0 && out_kind == '0
                               && out_data_a == '0 && out_data_b == '0)
    else $error("refused request carries event data");

  // back-to-back results differ in count by at most one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready ##1 rsp_valid |->
      occupancy == $past(occupancy) ||
      occupancy == OCC_W'($past(occupancy) + OCC_W'(1)) ||
      occupancy == OCC_W'($past(occupancy) - OCC_W'(1)))
    else $error("occupancy jumped by more than one");

endmodule

bind stable_time_priority_queue stpq_checker u_stpq_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .done_res   (rsp.done_res),
  .out_time   (rsp.out_time),
  .out_kind   (rsp.out_kind),
  .out_data_a (rsp.out_data_a),
  .out_data_b (rsp.out_data_b),
  .occupancy  (rsp.occupancy),
  .is_empty   (rsp.is_empty)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: drives insert/remove transactions into stable_time_priority_queue
// and checks every result against a shadow event list kept alongside the block
// depends on stpq_pkg, stpq_req_if / stpq_rsp_if and the queue rtl

module testbench;
  import stpq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 550;
  localparam int HOLD_AFTER   = 200;
  localparam int HOLD_CYCLES  = 120;
  localparam int DRAIN_CYCLES = 4;

  // flavor of event times inside one random run
  typedef enum int {
    SPAN_TIGHT,
    SPAN_NEAR,
    SPAN_EDGE,
    SPAN_WIDE
  } span_t;

  typedef struct packed {
    op_t    op;
    entry_t ev;
  } request_t;

  typedef struct packed {
    logic               done_res;
    logic signed [31:0] out_time;
    logic        [15:0] out_kind;
    logic signed [31:0] out_data_a;
    logic signed [31:0] out_data_b;
    logic [OCC_W-1:0]   occupancy;
    logic               is_empty;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  stpq_req_if req_ch ();
  stpq_rsp_if rsp_ch ();

  stable_time_priority_queue uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  request_t pending[$];
  outcome_t expected_outcomes[$];
  entry_t   shadow_list [QUEUE_DEPTH];
  int       shadow_count = 0;
  int       errors = 0;
  int       cycle_count = 0;
  int       results_seen = 0;
  int       req_gap = 0;
  int       rsp_stall = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  bit       quiet = 1'b0;
  bit       req_taken = 1'b0;

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic entry_t make_entry(logic signed [31:0] t, logic [15:0] k,
                                        logic signed [31:0] a, logic signed [31:0] b);
    entry_t ev;
    ev.evt_time = t;
    ev.kind     = k;
    ev.data_a   = a;
    ev.data_b   = b;
    return ev;
  endfunction

  function automatic entry_t random_entry(span_t span);
    entry_t ev;
    int     pick;
    ev.kind   = 16'($urandom());
    ev.data_a = $urandom();
    ev.data_b = $urandom();
    pick      = $urandom_range(0, 3);
    case (span)
      SPAN_TIGHT: ev.evt_time = $urandom_range(0, 7);
      SPAN_NEAR:  ev.evt_time = int'($urandom_range(0, 200)) - 100;
      SPAN_EDGE: begin
        case (pick)
          0: ev.evt_time = 32'sh7fffffff;
          1: ev.evt_time = 32'sh80000000;
          2: ev.evt_time = 32'sh00000000;
          default: ev.evt_time = 32'shffffffff;
        endcase
      end
      default: ev.evt_time = $urandom();
    endcase
    return ev;
  endfunction

  // shadow of the event list: stable insert by signed time, remove from the head
  function automatic outcome_t step_event_list(request_t rq);
    outcome_t res;
    int       pos;
    res = '0;
    if (rq.op == OP_INSERT) begin
      if (shadow_count < QUEUE_DEPTH) begin
        pos = 0;
        // equal times go behind the queued ones
        while (pos < shadow_count &&
               $signed(shadow_list[pos].evt_time) <= $signed(rq.ev.evt_time))
          pos++;
        for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
        shadow_list[pos] = rq.ev;
        shadow_count++;
        res.done_res = 1'b1;
      end
    end else if (shadow_count > 0) begin
      res.out_time   = shadow_list[0].evt_time;
      res.out_kind   = shadow_list[0].kind;
      res.out_data_a = shadow_list[0].data_a;
      res.out_data_b = shadow_list[0].data_b;
      for (int i = 1; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
      shadow_count--;
      res.done_res = 1'b1;
    end
    res.occupancy = shadow_count[OCC_W-1:0];
    res.is_empty  = (shadow_count == 0);
    return res;
  endfunction

  task automatic check_field(string name, logic signed [63:0] exp_val,
                             logic signed [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  // monitor: predict on request transactions, compare on result transactions
  always @(posedge clk) begin
    outcome_t want;
    request_t seen;
    cycle_count++;
    if (cycle_count % 128 == 0) quiet = ($urandom_range(0, 3) == 0);
    req_taken = !rst && req_ch.valid && req_ch.ready;
    if (req_taken) begin
      seen.op          = req_ch.op;
      seen.ev.evt_time = req_ch.event_time;
      seen.ev.kind     = req_ch.event_kind;
      seen.ev.data_a   = req_ch.data_a;
      seen.ev.data_b   = req_ch.data_b;
      expected_outcomes.push_back(step_event_list(seen));
    end
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (expected_outcomes.size() == 0) begin
        $error("result transaction with no request outstanding");
        errors++;
      end else begin
        want = expected_outcomes.pop_front();
        check_field("done_res", 64'(want.done_res), 64'(rsp_ch.done_res));
        check_field("out_time", 64'($signed(want.out_time)),
                    64'($signed(rsp_ch.out_time)));
        check_field("out_kind", 64'(want.out_kind), 64'(rsp_ch.out_kind));
        check_field("out_data_a", 64'($signed(want.out_data_a)),
                    64'($signed(rsp_ch.out_data_a)));
        check_field("out_data_b", 64'($signed(want.out_data_b)),
                    64'($signed(rsp_ch.out_data_b)));
        check_field("occupancy", 64'(want.occupancy), 64'(rsp_ch.occupancy));
        check_field("is_empty", 64'(want.is_empty), 64'(rsp_ch.is_empty));
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // request driver: presents pending items, idles between transactions
  always @(negedge clk) begin
    bit       show;
    request_t nxt;
    if (!rst) begin
      show = req_ch.valid && !req_taken;
      // keep offering while the receiver holds off so the queue backs up
      if (req_ch.valid && req_taken) req_gap = (hold_left > 0) ? 0 : pick_gap();
      if (!show) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (pending.size() > 0) begin
          nxt = pending.pop_front();
          show = 1'b1;
          req_ch.op         <= nxt.op;
          req_ch.event_time <= nxt.ev.evt_time;
          req_ch.event_kind <= nxt.ev.kind;
          req_ch.data_a     <= nxt.ev.data_a;
          req_ch.data_b     <= nxt.ev.data_b;
        end
      end
      req_ch.valid <= show;
    end
  end

  // result ready: random stalls plus one long hold-off mid run
  always @(negedge clk) begin
    logic take;
    if (!rst) begin
      take = 1'b0;
      if (hold_left > 0) begin
        hold_left--;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end else if (rsp_stall > 0) begin
        rsp_stall--;
      end else begin
        take = 1'b1;
        if ($urandom_range(0, 3) == 0) rsp_stall = pick_gap();
      end
      rsp_ch.ready <= take;
    end
  end

  // stimulus, reset and final verdict
  initial begin : stimulus
    int    made;
    int    run_len;
    int    ins_pct;
    int    mode;
    span_t span;

    req_ch.valid      = 1'b0;
    req_ch.op         = OP_INSERT;
    req_ch.event_time = '0;
    req_ch.event_kind = '0;
    req_ch.data_a     = '0;
    req_ch.data_b     = '0;
    rsp_ch.ready      = 1'b0;

    // directed: remove on empty, time extremes, ties, fill past full, partial drain
    pending.push_back(request_t'{OP_REMOVE, random_entry(SPAN_WIDE)});
    pending.push_back(request_t'{OP_INSERT, make_entry(32'sh7fffffff, 16'hffff,
                                                       32'sh80000000, 32'sh7fffffff)});
    pending.push_back(request_t'{OP_INSERT, make_entry(32'sh80000000, 16'h0000,
                                                       32'sh7fffffff, 32'sh80000000)});
    pending.push_back(request_t'{OP_INSERT, make_entry(32'sh0, 16'h0001, 32'sh1, 32'sh2)});
    pending.push_back(request_t'{OP_INSERT, make_entry(32'sh0, 16'h0002, 32'sh3, 32'sh4)});
    pending.push_back(request_t'{OP_INSERT, make_entry(32'shffffffff, 16'h8000,
                                                       32'shffffffff, 32'sh0)});
    pending.push_back(request_t'{OP_INSERT, make_entry(32'sh7fffffff, 16'h0003,
                                                       32'sh5, 32'sh6)});
    pending.push_back(request_t'{OP_INSERT, make_entry(32'sh80000000, 16'h0004,
                                                       32'sh7, 32'sh8)});
    for (int i = 0; i < 9; i++)
      pending.push_back(request_t'{OP_INSERT, random_entry(SPAN_TIGHT)});
    // queue is full here, this one is refused
    pending.push_back(request_t'{OP_INSERT, random_entry(SPAN_WIDE)});
    for (int i = 0; i < 7; i++)
      pending.push_back(request_t'{OP_REMOVE, random_entry(SPAN_WIDE)});

    // random runs: fill-heavy, drain-heavy or mixed, each with its own time spread
    made = 0;
    while (made < RANDOM_ITEMS) begin
      run_len = $urandom_range(4, 40);
      mode    = $urandom_range(0, 2);
      ins_pct = (mode == 0) ? 85 : (mode == 1) ? 15 : 50;
      span    = span_t'($urandom_range(0, 3));
      for (int i = 0; i < run_len && made < RANDOM_ITEMS; i++) begin
        pending.push_back(request_t'{($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE,
                                     random_entry(span)});
        made++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every request to go through and every result to come back
    while (pending.size() > 0 || req_ch.valid || expected_outcomes.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/stpq_pkg.sv
src/stpq_if.sv
src/stpq_cell.sv
src/stable_time_priority_queue.sv
src/stpq_checker.sv
tb/testbench.sv
